// ===== hdl/tsa_pkg.sv =====
`timescale 1ns / 1ps

package tsa_pkg;

	localparam int FRACTION_BITS_AVG_DEF = 16;
	localparam int FRACTION_BITS_INV_DEF = 48;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 18;

	localparam logic [CFG_INDEX_W-1:0] CFG_STAT_MODE   = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_ZONE_OFFSET = 1'b1;

	typedef enum logic [2:0] {
		MODE_SUM     = 3'd0,
		MODE_MIN     = 3'd1,
		MODE_MAX     = 3'd2,
		MODE_AVG     = 3'd3,
		MODE_STD     = 3'd4,
		MODE_SUM_INV = 3'd5,
		MODE_AVG_INV = 3'd6
	} stat_mode_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_UPD,
		S_SQADD,
		S_INVADD,
		S_OUT,
		S_DIV,
		S_AVGFIN,
		S_INV6FIN,
		S_STDA,
		S_STDB,
		S_M2MUL,
		S_M2ADD,
		S_CMP,
		S_SQRT,
		S_DONE
	} state_t;

endpackage

// ===== hdl/timestamp_stats_accumulator_unit.sv =====
`timescale 1ns / 1ps

// channel  | handshake          | payload
// ---------+--------------------+--------------------------------------------
// input    | in_valid, in_stall | raw_time
// output   | out_valid, out_stall | aggregate, items_seen, overflow_flag
// config   | cfg_valid, cfg_ready | cfg_index, cfg_data
//
// one item at a time; sum/min/max update the accumulator then load the output, a
// reciprocal adds a restoring divide and an accumulate step, average a further
// divide by count, as does average of inverses; std adds the square sum, divides
// of both sums by count, a mean square from partial products and a square root
// reset clears the count, accumulators, sticky flag, registers and output valid
// in_stall is high from the transfer until the result enters the output register

module timestamp_stats_accumulator_unit #(
	parameter int FRACTION_BITS_AVG = tsa_pkg::FRACTION_BITS_AVG_DEF,
	parameter int FRACTION_BITS_INV = tsa_pkg::FRACTION_BITS_INV_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [31:0]                      raw_time,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [63:0]                      aggregate,
	output logic [31:0]                      items_seen,
	output logic                             overflow_flag,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tsa_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [tsa_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int DW = 128 + 2 * FRACTION_BITS_AVG;
	localparam int CW = $clog2(DW + 1);

	tsa_pkg::state_t state_q, state_d;
	tsa_pkg::state_t ret_q;
	tsa_pkg::stat_mode_t mode_q;
	logic signed [17:0] offset_q;

	logic [31:0]  count_q;
	logic [63:0]  acc_q;
	logic [127:0] sq_q;
	logic         sticky_q;
	logic [31:0]  v_q;
	logic         first_q;
	logic [63:0]  prod_q;
	logic [DW-1:0] div_x_q;
	logic [31:0]  div_r_q;
	logic [31:0]  div_d_q;
	logic [CW-1:0] cnt_q;
	logic [127:0] e2_q;
	logic [127:0] m2_q;
	logic         std_sat_q;
	logic [63:0]  mean_q;
	logic [1:0]   phase_q;
	logic [65:0]  sq_rem_q;
	logic [63:0]  root_q;
	logic [63:0]  agg_q;

	logic         out_valid_q;
	logic [63:0]  aggregate_q;
	logic [31:0]  items_q;
	logic         flag_q;

	// shared arithmetic
	logic [33:0]  t_sum;
	logic [31:0]  mul_a, mul_b;
	logic [63:0]  add_b;
	logic [64:0]  add_sum;
	logic [128:0] sq_sum;
	logic [32:0]  rem_sh;
	logic         div_ge;
	logic [65:0]  rt_sh, rt_trial;
	logic         rt_ge;
	logic [31:0]  n_div;
	logic         out_free;

	assign t_sum = {2'b00, raw_time} + {{16{offset_q[17]}}, offset_q};
	assign add_b = (state_q == tsa_pkg::S_INVADD) ? div_x_q[63:0] : {32'd0, v_q};
	assign add_sum = {1'b0, acc_q} + {1'b0, add_b};
	assign sq_sum = {1'b0, sq_q} + {65'd0, prod_q};
	assign rem_sh = {div_r_q, div_x_q[DW-1]};
	assign div_ge = rem_sh >= {1'b0, div_d_q};
	assign rt_sh = {sq_rem_q[63:0], e2_q[127:126]};
	assign rt_trial = {root_q, 2'b01};
	assign rt_ge = rt_sh >= rt_trial;
	assign n_div = (count_q == 32'd0) ? 32'd1 : count_q;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		mul_a = v_q;
		mul_b = v_q;
		if (state_q == tsa_pkg::S_M2MUL) begin
			case (phase_q)
				2'd0: begin
					mul_a = mean_q[31:0];
					mul_b = mean_q[31:0];
				end
				2'd1: begin
					mul_a = mean_q[31:0];
					mul_b = mean_q[63:32];
				end
				default: begin
					mul_a = mean_q[63:32];
					mul_b = mean_q[63:32];
				end
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tsa_pkg::S_IDLE: if (in_valid) state_d = tsa_pkg::S_UPD;
			tsa_pkg::S_UPD: begin
				case (mode_q)
					tsa_pkg::MODE_STD: state_d = tsa_pkg::S_SQADD;
					tsa_pkg::MODE_SUM_INV, tsa_pkg::MODE_AVG_INV:
						state_d = (v_q == 32'd0) ? tsa_pkg::S_OUT : tsa_pkg::S_DIV;
					default: state_d = tsa_pkg::S_OUT;
				endcase
			end
			tsa_pkg::S_SQADD:  state_d = tsa_pkg::S_OUT;
			tsa_pkg::S_INVADD: state_d = tsa_pkg::S_OUT;
			tsa_pkg::S_OUT: begin
				case (mode_q)
					tsa_pkg::MODE_AVG, tsa_pkg::MODE_STD,
					tsa_pkg::MODE_AVG_INV: state_d = tsa_pkg::S_DIV;
					default: state_d = tsa_pkg::S_DONE;
				endcase
			end
			tsa_pkg::S_DIV: if (cnt_q == CW'(1)) state_d = ret_q;
			tsa_pkg::S_AVGFIN:  state_d = tsa_pkg::S_DONE;
			tsa_pkg::S_INV6FIN: state_d = tsa_pkg::S_DONE;
			tsa_pkg::S_STDA:    state_d = tsa_pkg::S_DIV;
			tsa_pkg::S_STDB: begin
				if (std_sat_q || ((div_x_q >> (32 + FRACTION_BITS_AVG)) != '0))
					state_d = tsa_pkg::S_DONE;
				else
					state_d = tsa_pkg::S_M2MUL;
			end
			tsa_pkg::S_M2MUL: state_d = tsa_pkg::S_M2ADD;
			tsa_pkg::S_M2ADD:
				state_d = (phase_q == 2'd2) ? tsa_pkg::S_CMP : tsa_pkg::S_M2MUL;
			tsa_pkg::S_CMP: state_d = (m2_q > e2_q) ? tsa_pkg::S_DONE : tsa_pkg::S_SQRT;
			tsa_pkg::S_SQRT: if (cnt_q == CW'(1)) state_d = tsa_pkg::S_DONE;
			tsa_pkg::S_DONE: if (out_free) state_d = tsa_pkg::S_IDLE;
			default: state_d = tsa_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall      = (state_q != tsa_pkg::S_IDLE);
		cfg_ready     = 1'b1;
		out_valid     = out_valid_q;
		aggregate     = aggregate_q;
		items_seen    = items_q;
		overflow_flag = flag_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tsa_pkg::S_IDLE;
			mode_q      <= tsa_pkg::MODE_SUM;
			offset_q    <= '0;
			count_q     <= '0;
			acc_q       <= '0;
			sq_q        <= '0;
			sticky_q    <= 1'b0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			phase_q     <= '0;
			ret_q       <= tsa_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				unique case (cfg_index)
					tsa_pkg::CFG_STAT_MODE:   mode_q <= tsa_pkg::stat_mode_t'(cfg_data[2:0]);
					tsa_pkg::CFG_ZONE_OFFSET: offset_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid_q && !out_stall && (state_q != tsa_pkg::S_DONE))
				out_valid_q <= 1'b0;

			unique case (state_q)
				tsa_pkg::S_IDLE: if (in_valid) begin
					first_q <= (count_q == 32'd0);
					if (t_sum[33])
						v_q <= 32'd0;
					else if (t_sum[32])
						v_q <= '1;
					else
						v_q <= t_sum[31:0];
					if (t_sum[33] || t_sum[32] || (count_q == '1)) sticky_q <= 1'b1;
					if (count_q != '1) count_q <= count_q + 32'd1;
				end
				tsa_pkg::S_UPD: begin
					case (mode_q)
						tsa_pkg::MODE_MIN:
							if (first_q || ({32'd0, v_q} < acc_q)) acc_q <= {32'd0, v_q};
						tsa_pkg::MODE_MAX:
							if (first_q || ({32'd0, v_q} > acc_q)) acc_q <= {32'd0, v_q};
						tsa_pkg::MODE_SUM_INV, tsa_pkg::MODE_AVG_INV: begin
							if (v_q == 32'd0) begin
								acc_q <= '1;
								sticky_q <= 1'b1;
							end else begin
								div_x_q <= {1'b1, {(DW-1){1'b0}}};
								div_r_q <= '0;
								div_d_q <= v_q;
								cnt_q   <= CW'(FRACTION_BITS_INV + 1);
								ret_q   <= tsa_pkg::S_INVADD;
							end
						end
						default: begin
							if (add_sum[64]) begin
								acc_q <= '1;
								sticky_q <= 1'b1;
							end else begin
								acc_q <= add_sum[63:0];
							end
						end
					endcase
				end
				tsa_pkg::S_SQADD: begin
					if (sq_sum[128]) begin
						sq_q <= '1;
						sticky_q <= 1'b1;
					end else begin
						sq_q <= sq_sum[127:0];
					end
				end
				tsa_pkg::S_INVADD: begin
					if (add_sum[64]) begin
						acc_q <= '1;
						sticky_q <= 1'b1;
					end else begin
						acc_q <= add_sum[63:0];
					end
				end
				tsa_pkg::S_OUT: begin
					agg_q   <= acc_q;
					div_r_q <= '0;
					div_d_q <= n_div;
					case (mode_q)
						tsa_pkg::MODE_AVG: begin
							div_x_q <= DW'(acc_q) << (DW - 64);
							cnt_q   <= CW'(64 + FRACTION_BITS_AVG);
							ret_q   <= tsa_pkg::S_AVGFIN;
						end
						tsa_pkg::MODE_STD: begin
							div_x_q <= DW'(sq_q) << (DW - 128);
							cnt_q   <= CW'(DW);
							ret_q   <= tsa_pkg::S_STDA;
						end
						default: begin
							div_x_q <= DW'(acc_q) << (DW - 64);
							cnt_q   <= CW'(64);
							ret_q   <= tsa_pkg::S_INV6FIN;
						end
					endcase
				end
				tsa_pkg::S_DIV: begin
					div_x_q <= {div_x_q[DW-2:0], div_ge};
					div_r_q <= div_ge ? 32'(rem_sh - {1'b0, div_d_q}) : rem_sh[31:0];
					cnt_q   <= cnt_q - CW'(1);
				end
				tsa_pkg::S_AVGFIN: begin
					if ((div_x_q >> 64) != '0) begin
						agg_q <= '1;
						sticky_q <= 1'b1;
					end else begin
						agg_q <= div_x_q[63:0];
					end
				end
				tsa_pkg::S_INV6FIN: agg_q <= div_x_q[63:0];
				tsa_pkg::S_STDA: begin
					std_sat_q <= (div_x_q >> (64 + 2 * FRACTION_BITS_AVG)) != '0;
					e2_q    <= div_x_q[127:0];
					div_x_q <= DW'(acc_q) << (DW - 64);
					div_r_q <= '0;
					cnt_q   <= CW'(64 + FRACTION_BITS_AVG);
					ret_q   <= tsa_pkg::S_STDB;
				end
				tsa_pkg::S_STDB: begin
					if (std_sat_q || ((div_x_q >> (32 + FRACTION_BITS_AVG)) != '0)) begin
						agg_q <= '1;
						sticky_q <= 1'b1;
					end
					mean_q  <= div_x_q[63:0];
					m2_q    <= '0;
					phase_q <= 2'd0;
				end
				tsa_pkg::S_M2MUL: ;
				tsa_pkg::S_M2ADD: begin
					case (phase_q)
						2'd0:    m2_q <= m2_q + {64'd0, prod_q};
						2'd1:    m2_q <= m2_q + ({64'd0, prod_q} << 33);
						default: m2_q <= m2_q + ({64'd0, prod_q} << 64);
					endcase
					phase_q <= phase_q + 2'd1;
				end
				tsa_pkg::S_CMP: begin
					agg_q    <= '0;
					e2_q     <= e2_q - m2_q;
					sq_rem_q <= '0;
					root_q   <= '0;
					cnt_q    <= CW'(64);
				end
				tsa_pkg::S_SQRT: begin
					sq_rem_q <= rt_ge ? (rt_sh - rt_trial) : rt_sh;
					root_q   <= {root_q[62:0], rt_ge};
					e2_q     <= {e2_q[125:0], 2'b00};
					cnt_q    <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) agg_q <= {root_q[62:0], rt_ge};
				end
				tsa_pkg::S_DONE: if (out_free) begin
					out_valid_q <= 1'b1;
					aggregate_q <= agg_q;
					items_q     <= count_q;
					flag_q      <= sticky_q;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	a_sticky_holds: assert property (@(posedge clk) disable iff (!arst_n)
		sticky_q |=> sticky_q) else $error("sticky overflow cleared");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> items_seen != 32'd0) else $error("result with zero count");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tsa_pkg::S_DIV || state_q == tsa_pkg::S_SQRT) |-> cnt_q != '0)
		else $error("iteration counter ran out");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> state_q != tsa_pkg::S_IDLE)
		else $error("transfer did not start work");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

	localparam int LIMIT_CYCLES = 3000000;
	localparam logic [2:0] MODE_SPARE = 3'd7;
	localparam logic [31:0] MAX32 = 32'hFFFFFFFF;
	localparam logic [63:0] MAX64 = 64'hFFFFFFFFFFFFFFFF;

	typedef struct {
		logic [63:0] aggregate;
		logic [31:0] items_seen;
		logic        overflow_flag;
	} stat_result_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [31:0] raw_time = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [63:0] aggregate;
	logic [31:0] items_seen;
	logic overflow_flag;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [tsa_pkg::CFG_INDEX_W-1:0] cfg_index = tsa_pkg::CFG_STAT_MODE;
	logic [tsa_pkg::CFG_DATA_W-1:0] cfg_data = 0;

	timestamp_stats_accumulator_unit DUT (.*);

	// predictor state
	logic [31:0] count_q;
	logic [63:0] acc_q;
	logic [127:0] sqsum_q;
	logic sticky_q;
	logic [2:0] mode_q;
	logic signed [17:0] zone_q;

	logic [31:0] times_pending[$];
	stat_result_t results_due[$];
	int send_idle, recv_idle;
	int mismatches;
	int cycles;

	initial forever #4 clk = ~clk;

	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s[64]) begin
			sticky_q = 1;
			return MAX64;
		end
		return s[63:0];
	endfunction

	function automatic logic [63:0] root_of(input logic [127:0] x);
		logic [63:0] r, cand;
		r = 0;
		for (int b = 63; b >= 0; b--) begin
			cand = r | (64'd1 << b);
			if ({64'b0, cand} * {64'b0, cand} <= x)
				r = cand;
		end
		return r;
	endfunction

	function automatic logic [63:0] spread_of(input logic [63:0] n);
		logic [127:0] q1;
		logic [159:0] e2;
		logic [127:0] mean_w, m2;
		q1 = sqsum_q / n;
		if (q1[127:64] != 0 || acc_q / n > {32'b0, MAX32}) begin
			sticky_q = 1;
			return MAX64;
		end
		e2 = ({32'b0, sqsum_q} << 32) / n;
		mean_w = ({64'b0, acc_q} << 16) / n;
		m2 = mean_w * mean_w;
		if (m2 > e2[127:0])
			return 0;
		return root_of(e2[127:0] - m2);
	endfunction

	function automatic void predict_time(input logic [31:0] raw);
		logic signed [35:0] t;
		logic [31:0] v;
		logic [128:0] s129;
		logic [127:0] wide;
		logic [63:0] n, agg;
		bit first;
		stat_result_t r;
		first = (count_q == 0);
		t = $signed({4'b0, raw}) + zone_q;
		if (t < 0) begin
			v = 0;
			sticky_q = 1;
		end else if (t > $signed({4'b0, MAX32})) begin
			v = MAX32;
			sticky_q = 1;
		end else begin
			v = t[31:0];
		end
		if (count_q == MAX32)
			sticky_q = 1;
		else
			count_q++;
		case (mode_q)
			tsa_pkg::MODE_MIN: if (first || v < acc_q) acc_q = {32'b0, v};
			tsa_pkg::MODE_MAX: if (first || v > acc_q) acc_q = {32'b0, v};
			tsa_pkg::MODE_STD: begin
				s129 = {1'b0, sqsum_q} + {65'b0, v} * {65'b0, v};
				if (s129[128]) begin
					sticky_q = 1;
					sqsum_q = '1;
				end else begin
					sqsum_q = s129[127:0];
				end
				acc_q = sat_add(acc_q, {32'b0, v});
			end
			tsa_pkg::MODE_SUM_INV, tsa_pkg::MODE_AVG_INV: begin
				if (v == 0) begin
					acc_q = MAX64;
					sticky_q = 1;
				end else begin
					acc_q = sat_add(acc_q, (64'd1 << 48) / {32'b0, v});
				end
			end
			default: acc_q = sat_add(acc_q, {32'b0, v});
		endcase
		n = (count_q == 0) ? 64'd1 : {32'b0, count_q};
		case (mode_q)
			tsa_pkg::MODE_AVG: begin
				wide = ({64'b0, acc_q} << 16) / n;
				if (wide[127:64] != 0) begin
					sticky_q = 1;
					agg = MAX64;
				end else begin
					agg = wide[63:0];
				end
			end
			tsa_pkg::MODE_STD: agg = spread_of(n);
			tsa_pkg::MODE_AVG_INV: agg = acc_q / n;
			default: agg = acc_q;
		endcase
		r.aggregate = agg;
		r.items_seen = count_q;
		r.overflow_flag = sticky_q;
		results_due.push_back(r);
	endfunction

	// driver
	always @(posedge clk) begin
		logic nv;
		nv = in_valid;
		if (in_valid && !in_stall) begin
			predict_time(raw_time);
			nv = 0;
		end
		if (!nv && times_pending.size() > 0 && $urandom_range(99) >= send_idle) begin
			raw_time <= times_pending.pop_front();
			nv = 1;
		end
		in_valid <= nv;
	end

	// monitor
	always @(posedge clk) begin
		stat_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (results_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transfer: agg %h items %0d flag %0b",
						aggregate, items_seen, overflow_flag);
			end else begin
				e = results_due.pop_front();
				if (e.aggregate !== aggregate || e.items_seen !== items_seen
						|| e.overflow_flag !== overflow_flag) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp agg %h items %0d flag %0b, got agg %h items %0d flag %0b",
							e.aggregate, e.items_seen, e.overflow_flag,
							aggregate, items_seen, overflow_flag);
				end
			end
		end
		out_stall <= ($urandom_range(99) < recv_idle);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("FAILURE");
			$finish;
		end
	end

	// wait on settled values until nothing is queued, offered or outstanding
	task automatic drain();
		do @(negedge clk);
		while (times_pending.size() != 0 || in_valid || results_due.size() != 0);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [tsa_pkg::CFG_INDEX_W-1:0] idx,
			input logic [tsa_pkg::CFG_DATA_W-1:0] d);
		drain();
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= d;
		forever begin
			@(posedge clk);
			if (cfg_ready) break;
		end
		if (idx == tsa_pkg::CFG_STAT_MODE)
			mode_q = d[2:0];
		else
			zone_q = d;
		cfg_valid <= 0;
	endtask

	task automatic set_mode(input logic [2:0] md);
		write_reg(tsa_pkg::CFG_STAT_MODE, {15'd0, md});
	endtask

	function automatic logic [31:0] pick_time();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(0, 20);
			2: return MAX32 - $urandom_range(0, 100000);
			default: return $urandom_range(1000000000, 2000000000);
		endcase
	endfunction

	initial begin
		logic [2:0] m;
		logic signed [17:0] z;
		count_q = 0;
		acc_q = 0;
		sqsum_q = 0;
		sticky_q = 0;
		mode_q = tsa_pkg::MODE_SUM;
		zone_q = 0;
		mismatches = 0;
		cycles = 0;
		send_idle = 0;
		recv_idle = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;

		// field extremes and offset clamps
		times_pending = '{32'd0, MAX32, 32'd1};
		write_reg(tsa_pkg::CFG_ZONE_OFFSET, 18'sd86400);
		times_pending = '{MAX32, 32'd5};
		write_reg(tsa_pkg::CFG_ZONE_OFFSET, -18'sd86400);
		times_pending = '{32'd0, 32'd100000};
		write_reg(tsa_pkg::CFG_ZONE_OFFSET, 18'sd0);
		// every mode other than sum, zero reciprocal, saturated accumulator seen by later modes
		set_mode(tsa_pkg::MODE_MIN);
		times_pending = '{32'd900, 32'd50, 32'd70};
		set_mode(tsa_pkg::MODE_MAX);
		times_pending = '{32'd3, 32'd4000};
		set_mode(tsa_pkg::MODE_AVG);
		times_pending = '{32'd7};
		set_mode(tsa_pkg::MODE_STD);
		times_pending = '{32'd11, MAX32};
		set_mode(tsa_pkg::MODE_AVG_INV);
		times_pending = '{32'd3, 32'd1};
		set_mode(tsa_pkg::MODE_SUM_INV);
		times_pending = '{32'd0, 32'd2};
		set_mode(tsa_pkg::MODE_AVG);
		times_pending = '{32'd9};
		set_mode(tsa_pkg::MODE_STD);
		times_pending = '{32'd9};
		set_mode(MODE_SPARE);
		times_pending = '{32'd1};
		set_mode(tsa_pkg::MODE_MIN);
		times_pending = '{32'd12};

		for (int regime = 0; regime < 3; regime++) begin
			send_idle = (regime == 0) ? 10 : (regime == 1) ? 75 : 0;
			recv_idle = (regime == 0) ? 75 : (regime == 1) ? 10 : 0;
			for (int p = 0; p < 8; p++) begin
				m = 3'(p);
				z = (p == 0) ? 18'sd86400 : (p == 1) ? -18'sd86400 :
					18'($signed($urandom_range(0, 172800)) - 86400);
				set_mode(m);
				write_reg(tsa_pkg::CFG_ZONE_OFFSET, z);
				for (int i = 0; i < 68; i++)
					times_pending.push_back(pick_time());
			end
		end

		drain();
		repeat (400) @(posedge clk);
		if (mismatches == 0 && results_due.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/tsa_pkg.sv
hdl/timestamp_stats_accumulator_unit.sv
bench/tb.sv
